[rtl/dgs_pkg.sv]
`timescale 1ns / 1ps

package dgs_pkg;

    localparam int TABLE_DEPTH   = 512;
    localparam int TABLE_AW      = 9;
    localparam int RES_BITS      = 64;
    localparam int CNT_BITS      = 7;
    localparam int WORD_BITS     = 32;
    localparam int IN_DATA_BITS  = 56;
    localparam int SAMPLE_BITS   = 16;
    localparam int PADDR_BITS    = 4;

    localparam logic [4:0] MAX_ROWS_M1    = 5'd31;
    localparam logic [4:0] MAX_ROW_BYTES  = 5'd16;
    localparam logic [4:0] BINARY_LIMIT   = 5'd16;
    localparam logic [4:0] LAST_RESULT    = 5'd20;

    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES    = 2'd1;
    localparam logic [1:0] REG_SCALE_K      = 2'd2;
    localparam logic [1:0] REG_SCALE_K_BITS = 2'd3;

    localparam logic CMD_TABLE   = 1'b0;
    localparam logic CMD_ENTROPY = 1'b1;

    typedef enum logic [2:0] {
        PH_BIN_FIRST,
        PH_BIN_ROUND,
        PH_DRAW_Y,
        PH_DRAW_U,
        PH_BER
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_RUN,
        ST_LOOKUP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [4:0] rows_m1;
        logic [4:0] rb;
        logic [9:0] k;
        logic [3:0] kb;
    } t_cfg;

    typedef struct packed {
        logic take_in;
        logic write_table;
        logic append;
        logic step;
        logic use_table;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic starved;
        logic need_read;
        logic accept;
        logic out_free;
    } t_status;

endpackage

[rtl/dgs_ctrl.sv]
`timescale 1ns / 1ps

module dgs_ctrl
    import dgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_command,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_nres;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_command == CMD_ENTROPY) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.starved) begin
                    n_state = ST_FLUSH;
                end else if (i_status.need_read) begin
                    n_state = ST_LOOKUP;
                end else if (i_status.out_free && i_status.accept && r_nres == LAST_RESULT) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_LOOKUP: begin
                if (i_status.out_free) begin
                    if (i_status.accept && r_nres == LAST_RESULT) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.take_in     = i_in_valid;
                o_cmd.write_table = i_in_valid && i_in_command == CMD_TABLE;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
            end
            ST_RUN: begin
                o_cmd.step = !i_status.starved && !i_status.need_read && i_status.out_free;
            end
            ST_LOOKUP: begin
                o_cmd.step      = i_status.out_free;
                o_cmd.use_table = 1'b1;
            end
            ST_FLUSH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nres  <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.append) begin
                r_nres <= '0;
            end else if (o_cmd.step && i_status.accept) begin
                r_nres <= r_nres + 5'd1;
            end
        end
    end

endmodule

[rtl/dgs_dp.sv]
`timescale 1ns / 1ps

module dgs_dp
    import dgs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  t_cfg                   i_cfg,
    input  logic [TABLE_AW-1:0]    i_table_address,
    input  logic [7:0]             i_table_byte,
    input  logic [WORD_BITS-1:0]   i_entropy_word,
    input  logic                   i_out_ready,
    output t_status                o_status,
    output logic                   o_out_valid,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_last
);

    logic [7:0]            r_mem [TABLE_DEPTH];
    logic [7:0]            r_rd;
    logic [WORD_BITS-1:0]  r_word;
    logic [RES_BITS-1:0]   r_res;
    logic [CNT_BITS-1:0]   r_cnt;
    t_phase                r_phase;
    logic [4:0]            r_x;
    logic [9:0]            r_y;
    logic                  r_u;
    logic [31:0]           r_e;
    logic [4:0]            r_row;
    logic [4:0]            r_byte;
    logic [14:0]           r_kx;
    logic                  r_pend_v;
    logic [SAMPLE_BITS-1:0] r_pend_s;
    logic                  r_out_v;
    logic [SAMPLE_BITS-1:0] r_out_s;
    logic                  r_out_last;

    logic [4:0]            w_i;
    logic [4:0]            w_need;
    logic [31:0]           w_mask;
    logic [31:0]           w_v;
    logic                  w_bit;
    logic                  w_byte_end;
    logic                  w_passed;
    logic                  w_accept;
    logic                  w_reject;
    logic [4:0]            w_byte_inc;
    logic [9:0]            w_addr;
    logic [16:0]           w_sum;
    logic [31:0]           w_e;
    logic [15:0]           w_mag;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic                  w_out_free;
    logic                  w_push;

    assign w_i = (r_x == 5'd0) ? 5'd1 : ((r_x > BINARY_LIMIT) ? BINARY_LIMIT : r_x);
    assign w_bit      = r_e[r_row];
    assign w_byte_end = r_byte >= i_cfg.rb;

    always_comb begin
        case (r_phase)
            PH_BIN_FIRST: w_need = 5'd1;
            PH_BIN_ROUND: w_need = 5'((6'(w_i) << 1) - 6'd1);
            PH_DRAW_Y:    w_need = (i_cfg.kb == 4'd0) ? 5'd1 : 5'(i_cfg.kb);
            PH_DRAW_U:    w_need = 5'd1;
            PH_BER:       w_need = (w_bit && !w_byte_end) ? 5'd8 : 5'd0;
            default:      w_need = 5'd0;
        endcase
    end

    assign w_mask = 32'((33'd1 << w_need) - 33'd1);
    assign w_v    = r_res[31:0] & w_mask;
    assign w_byte_inc = r_byte + 5'd1;

    always_comb begin
        w_passed = 1'b0;
        w_reject = 1'b0;
        if (w_bit) begin
            if (w_byte_end) begin
                w_passed = 1'b1;
            end else if (i_cmd.use_table) begin
                if (w_v[7:0] > r_rd) begin
                    w_reject = 1'b1;
                end else if (w_v[7:0] < r_rd) begin
                    w_passed = 1'b1;
                end else begin
                    w_passed = w_byte_inc >= i_cfg.rb;
                end
            end
        end
        w_accept = (r_phase == PH_BER) && (r_row == 5'd0) && (!w_bit || w_passed);
    end

    assign w_addr = 10'(r_row) * 10'(i_cfg.rb) + 10'(r_byte);
    assign w_sum  = 17'(r_kx) + 17'(r_kx) + 17'(r_y);
    assign w_e    = 32'(r_y) * 32'(w_sum);
    assign w_mag  = 16'(r_kx) + 16'(r_y);
    assign w_sample = r_u ? w_mag : 16'(16'd0 - w_mag);
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_push = r_pend_v && ((i_cmd.step && w_accept) || i_cmd.finish);

    assign o_status.starved   = 7'(w_need) > r_cnt;
    assign o_status.need_read = (r_phase == PH_BER) && w_bit && !w_byte_end;
    assign o_status.accept    = w_accept;
    assign o_status.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_table) begin
            r_mem[i_table_address] <= i_table_byte;
        end
        r_rd <= r_mem[w_addr[TABLE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_word <= i_entropy_word;
        end
        r_kx <= 15'(i_cfg.k) * 15'(r_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res      <= '0;
            r_cnt      <= '0;
            r_phase    <= PH_BIN_FIRST;
            r_x        <= '0;
            r_y        <= '0;
            r_u        <= 1'b0;
            r_e        <= '0;
            r_row      <= '0;
            r_byte     <= '0;
            r_pend_v   <= 1'b0;
            r_pend_s   <= '0;
            r_out_v    <= 1'b0;
            r_out_s    <= '0;
            r_out_last <= 1'b0;
        end else begin
            if (i_out_ready && !w_push) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.append) begin
                r_res <= r_res | (RES_BITS'(r_word) << r_cnt);
                r_cnt <= r_cnt + CNT_BITS'(WORD_BITS);
            end
            if (i_cmd.step) begin
                r_res <= r_res >> w_need;
                r_cnt <= r_cnt - 7'(w_need);
                case (r_phase)
                    PH_BIN_FIRST: begin
                        if (w_v[0]) begin
                            r_x     <= 5'd0;
                            r_phase <= PH_DRAW_Y;
                        end else begin
                            r_x     <= 5'd1;
                            r_phase <= PH_BIN_ROUND;
                        end
                    end
                    PH_BIN_ROUND: begin
                        if (w_v == 32'd0) begin
                            r_x     <= w_i;
                            r_phase <= PH_DRAW_Y;
                        end else if (w_v != 32'd1) begin
                            r_phase <= PH_BIN_FIRST;
                        end else if (w_i == BINARY_LIMIT) begin
                            r_x     <= 5'd0;
                            r_phase <= PH_DRAW_Y;
                        end else begin
                            r_x <= w_i + 5'd1;
                        end
                    end
                    PH_DRAW_Y: begin
                        if (w_v < 32'(i_cfg.k)) begin
                            r_y     <= w_v[9:0];
                            r_phase <= PH_DRAW_U;
                        end
                    end
                    PH_DRAW_U: begin
                        r_u <= w_v[0];
                        r_e <= w_e;
                        if (r_x == 5'd0 && r_y == 10'd0 && !w_v[0]) begin
                            r_phase <= PH_BIN_FIRST;
                        end else begin
                            r_row   <= i_cfg.rows_m1;
                            r_byte  <= 5'd0;
                            r_phase <= PH_BER;
                        end
                    end
                    PH_BER: begin
                        if (w_reject) begin
                            r_phase <= PH_BIN_FIRST;
                        end else if (w_accept) begin
                            r_byte  <= 5'd0;
                            r_phase <= PH_BIN_FIRST;
                            r_pend_v <= 1'b1;
                            r_pend_s <= w_sample;
                            if (r_pend_v) begin
                                r_out_v    <= 1'b1;
                                r_out_s    <= r_pend_s;
                                r_out_last <= 1'b0;
                            end
                        end else if (w_passed) begin
                            r_byte <= 5'd0;
                            r_row  <= r_row - 5'd1;
                        end else if (!w_bit) begin
                            r_row <= r_row - 5'd1;
                        end else begin
                            r_byte <= w_byte_inc;
                        end
                    end
                    default: begin
                        r_phase <= PH_BIN_FIRST;
                    end
                endcase
            end
            if (i_cmd.finish && r_pend_v) begin
                r_pend_v   <= 1'b0;
                r_out_v    <= 1'b1;
                r_out_s    <= r_pend_s;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_sample    = r_out_s;
    assign o_last      = r_out_last;

endmodule

[rtl/discrete_gaussian_sampler.sv]
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_*       in         tuser: command; tdata: table_address, table_byte, entropy_word
// m_*       out        tdata: sample; tlast: last_of_word
// APB       in/out     four registers at byte addresses 0, 4, 8 and 12
//
// A table beat is written in the cycle it is accepted. After an entropy beat the input
// stays closed through the append, every sampler step, a lookup for each table byte
// tested, since the table memory has a registered read port, and a flush when the word
// ends, because the reservoir ran dry or the last result of the word was accepted.
// Most steps take reservoir bits, but row walks take none, so a word may run long.
// Reset is synchronous and clears the reservoir and sampler state, not the table.
// A stalled output holds the sampler; input is taken only when the block is idle.

module discrete_gaussian_sampler
    import dgs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_BITS-1:0] s_tdata,   // table_address, table_byte, entropy_word
    input  logic                    s_tuser,   // command
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SAMPLE_BITS-1:0]  m_tdata,   // sample
    output logic                    m_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_BITS-1:0]   paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [5:0] r_row_count;
    logic [4:0] r_row_bytes;
    logic [9:0] r_scale_k;
    logic [3:0] r_scale_k_bits;
    t_cfg       w_cfg;
    t_cmd       w_cmd;
    t_status    w_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= 6'd23;
            r_row_bytes    <= 5'd8;
            r_scale_k      <= 10'd254;
            r_scale_k_bits <= 4'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ROW_COUNT:    r_row_count    <= pwdata[5:0];
                REG_ROW_BYTES:    r_row_bytes    <= pwdata[4:0];
                REG_SCALE_K:      r_scale_k      <= pwdata[9:0];
                REG_SCALE_K_BITS: r_scale_k_bits <= pwdata[3:0];
                default:          r_row_count    <= r_row_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROW_COUNT:    prdata = 32'(r_row_count);
            REG_ROW_BYTES:    prdata = 32'(r_row_bytes);
            REG_SCALE_K:      prdata = 32'(r_scale_k);
            REG_SCALE_K_BITS: prdata = 32'(r_scale_k_bits);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_row_count == 6'd0) begin
            w_cfg.rows_m1 = 5'd0;
        end else if (r_row_count > 6'd32) begin
            w_cfg.rows_m1 = MAX_ROWS_M1;
        end else begin
            w_cfg.rows_m1 = 5'(r_row_count - 6'd1);
        end
        if (r_row_bytes == 5'd0) begin
            w_cfg.rb = 5'd1;
        end else if (r_row_bytes > MAX_ROW_BYTES) begin
            w_cfg.rb = MAX_ROW_BYTES;
        end else begin
            w_cfg.rb = r_row_bytes;
        end
        w_cfg.k  = r_scale_k;
        w_cfg.kb = r_scale_k_bits;
    end

    dgs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_command (s_tuser),
        .i_status     (w_status),
        .o_in_ready   (s_tready),
        .o_cmd        (w_cmd)
    );

    dgs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_table_address (s_tdata[8:0]),
        .i_table_byte    (s_tdata[16:9]),
        .i_entropy_word  (s_tdata[48:17]),
        .i_out_ready     (m_tready),
        .o_status        (w_status),
        .o_out_valid     (m_tvalid),
        .o_sample        (m_tdata),
        .o_last          (m_tlast)
    );

endmodule

[rtl/dgs_checker.sv]
`timescale 1ns / 1ps

module dgs_sva
    import dgs_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    s_tuser,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [SAMPLE_BITS-1:0]  m_tdata,
    input logic                    m_tlast,
    input logic                    pready
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("outputs not quiet after reset");

    a_busy_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser == CMD_ENTROPY |=> !s_tready)
        else $error("input taken while a word is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind discrete_gaussian_sampler dgs_sva u_dgs_sva (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

[test/dgs_checker.sv]
`timescale 1ns / 1ps

module dgs_checker
    import dgs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [SAMPLE_BITS-1:0]  m_tdata,
    input  logic                    m_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_BITS-1:0]   paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_samples
);

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_sample;

    t_sample        sample_q[$];
    logic [7:0]     prob_mem[TABLE_DEPTH];
    logic [63:0]    pool;
    int unsigned    pool_cnt;
    t_phase         phase;
    int unsigned    gx, gy, gu, expo, row_i, byte_i;
    int unsigned    r_rows, r_rb, r_k, r_kb;

    assign o_pending = sample_q.size();

    function automatic int unsigned take(input int unsigned n);
        int unsigned v;
        v = int'(pool & ((64'd1 << n) - 64'd1));
        pool = pool >> n;
        pool_cnt = pool_cnt - n;
        return v;
    endfunction

    function automatic int unsigned clampu(input int unsigned v, lo, hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic draw_samples(input logic [31:0] w);
        int unsigned rows, rb, kb, i, need, v, made, uc, p, val;
        bit stop, passed, acc, found;
        t_sample s;
        rows = clampu(r_rows, 1, 32);
        rb = clampu(r_rb, 1, 16);
        kb = (r_kb == 0) ? 1 : r_kb;
        pool = pool | ({32'd0, w} << pool_cnt);
        pool_cnt = pool_cnt + 32;
        made = 0;
        stop = 0;
        while (made < 21 && !stop) begin
            case (phase)
                PH_BIN_FIRST: begin
                    if (pool_cnt < 1) stop = 1;
                    else if (take(1) != 0) begin
                        gx = 0;
                        phase = PH_DRAW_Y;
                    end else begin
                        gx = 1;
                        phase = PH_BIN_ROUND;
                    end
                end
                PH_BIN_ROUND: begin
                    i = clampu(gx, 1, 16);
                    need = 2 * i - 1;
                    if (pool_cnt < need) stop = 1;
                    else begin
                        v = take(need);
                        if (v == 0) begin
                            gx = i;
                            phase = PH_DRAW_Y;
                        end else if (v != 1) begin
                            phase = PH_BIN_FIRST;
                        end else if (i + 1 > 16) begin
                            gx = 0;
                            phase = PH_DRAW_Y;
                        end else begin
                            gx = i + 1;
                        end
                    end
                end
                PH_DRAW_Y: begin
                    if (pool_cnt < kb) stop = 1;
                    else begin
                        v = take(kb);
                        if (v < r_k) begin
                            gy = v;
                            phase = PH_DRAW_U;
                        end
                    end
                end
                PH_DRAW_U: begin
                    if (pool_cnt < 1) stop = 1;
                    else begin
                        gu = take(1);
                        expo = gy * (gy + 2 * r_k * gx);
                        if ((gx | gy | gu) == 0) begin
                            phase = PH_BIN_FIRST;
                        end else begin
                            row_i = rows - 1;
                            byte_i = 0;
                            phase = PH_BER;
                        end
                    end
                end
                default: begin
                    passed = 0;
                    acc = 0;
                    found = 0;
                    while (!found) begin
                        if (row_i < 32 && expo[row_i]) found = 1;
                        else if (row_i == 0) break;
                        else row_i--;
                    end
                    if (!found) acc = 1;
                    else if (byte_i >= rb) passed = 1;
                    else if (pool_cnt < 8) stop = 1;
                    else begin
                        uc = take(8);
                        p = prob_mem[row_i * rb + byte_i];
                        if (uc > p) phase = PH_BIN_FIRST;
                        else if (uc < p) passed = 1;
                        else begin
                            byte_i++;
                            if (byte_i >= rb) passed = 1;
                        end
                    end
                    if (passed) begin
                        byte_i = 0;
                        if (row_i == 0) acc = 1;
                        else row_i--;
                    end
                    if (acc) begin
                        val = r_k * gx + gy;
                        if (gu == 0) val = 0 - val;
                        s.sample = val[15:0];
                        s.last = 0;
                        sample_q.push_back(s);
                        made++;
                        phase = PH_BIN_FIRST;
                    end
                end
            endcase
        end
        if (made > 0) sample_q[sample_q.size() - 1].last = 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool = 0;
            pool_cnt = 0;
            phase = PH_BIN_FIRST;
            gx = 0; gy = 0; gu = 0; expo = 0; row_i = 0; byte_i = 0;
            r_rows = 23; r_rb = 8; r_k = 254; r_kb = 8;
            sample_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ROW_COUNT:    r_rows = pwdata[5:0];
                    REG_ROW_BYTES:    r_rb = pwdata[4:0];
                    REG_SCALE_K:      r_k = pwdata[9:0];
                    REG_SCALE_K_BITS: r_kb = pwdata[3:0];
                    default:          r_rows = r_rows;
                endcase
            end
            if (m_tvalid && m_tready) begin
                o_samples++;
                if (sample_q.size() == 0) begin
                    $error("sample beat with nothing expected: %0d", $signed(m_tdata));
                    o_errors++;
                end else begin
                    t_sample e;
                    e = sample_q.pop_front();
                    if (m_tdata !== e.sample) begin
                        $error("sample: expected %0d, got %0d",
                               $signed(e.sample), $signed(m_tdata));
                        o_errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_of_word: expected %0d, got %0d", e.last, m_tlast);
                        o_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_TABLE) prob_mem[s_tdata[8:0]] = s_tdata[16:9];
                else draw_samples(s_tdata[48:17]);
            end
        end
    end

    initial begin
        o_errors = 0;
        o_samples = 0;
    end

endmodule

[test/discrete_gaussian_sampler_tb.sv]
`timescale 1ns / 1ps

module discrete_gaussian_sampler_tb;
    import dgs_pkg::*;

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    s_tvalid = 0;
    logic                    s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata = '0;   // table_address, table_byte, entropy_word
    logic                    s_tuser = 0;    // command
    logic                    m_tvalid;
    logic                    m_tready = 0;
    logic [SAMPLE_BITS-1:0]  m_tdata;        // sample
    logic                    m_tlast;
    logic                    psel = 0;
    logic                    penable = 0;
    logic                    pwrite = 0;
    logic [PADDR_BITS-1:0]   paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    int errors, pending, samples;
    int words_sent = 0;
    int settings_used = 0;
    int hold_cycles = 0;
    int cycle_count = 0;

    discrete_gaussian_sampler dut (.*);

    dgs_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending), .o_samples(samples)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and holds off entirely while hold_cycles runs.
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if ($urandom_range(0, 5) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    bit gaps_on = 1;

    task automatic send_beat(input logic cmd, input logic [8:0] addr,
                             input logic [7:0] data, input logic [31:0] word);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, word, data, addr};
        if (cmd == CMD_ENTROPY) words_sent++;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic quiesce();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0 || !s_tready) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic apply_setting(input logic [31:0] rows, rb, k, kb);
        quiesce();
        apb_write(REG_ROW_COUNT, rows);
        apb_write(REG_ROW_BYTES, rb);
        apb_write(REG_SCALE_K, k);
        apb_write(REG_SCALE_K_BITS, kb);
        settings_used++;
    endtask

    task automatic random_words(input int count);
        repeat (count) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(CMD_TABLE, 9'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                          '0);
            else
                send_beat(CMD_ENTROPY, '0, '0, $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Rows never reach beyond 26 set exponent bits and rows hold at most two bytes,
        // so the first 64 table entries cover every read; most are high probabilities.
        gaps_on = 0;
        for (int a = 0; a < 64; a++)
            send_beat(CMD_TABLE, a[8:0],
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(224, 255)), '0);
        gaps_on = 1;
        send_beat(CMD_TABLE, 9'd511, 8'hff, '0);
        send_beat(CMD_TABLE, 9'd0, 8'h00, '0);
        send_beat(CMD_TABLE, 9'd0, 8'hf0, '0);
        apply_setting(23, 2, 254, 8);

        send_beat(CMD_ENTROPY, '0, '0, 32'h0000_0000);
        send_beat(CMD_ENTROPY, '0, '0, 32'hffff_ffff);
        send_beat(CMD_ENTROPY, '0, '0, 32'h5555_5555);
        send_beat(CMD_ENTROPY, '0, '0, 32'haaaa_aaaa);
        send_beat(CMD_ENTROPY, '0, '0, 32'h0000_0001);
        send_beat(CMD_ENTROPY, '0, '0, 32'hffff_fffe);
        random_words(15);

        // The sender keeps offering beats while the receiver holds off.
        hold_cycles = 600;
        random_words(10);

        apply_setting(1, 1, 1, 1);
        random_words(10);
        apply_setting(32, 2, 1023, 10);
        random_words(10);
        apply_setting(63, 2, 0, 0);
        random_words(4);
        apply_setting(0, 0, 3, 2);
        random_words(8);
        apply_setting(5, 2, 12, 4);
        random_words(10);
        apply_setting(23, 1, 254, 8);
        random_words(12);

        quiesce();
        $display("Sent %0d entropy words over %0d register settings; %0d samples checked.",
                 words_sent, settings_used, samples);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
